[src/jet_pkg.sv]
// ----------------------------------------------------------------------------
// jet_pkg: shared types and constants for the Julia escape-time core
// Fixed-point widths, register indexes and the words passed between blocks.
// ----------------------------------------------------------------------------
package jet_pkg;

	localparam int FRAC_BITS = 28;           // fraction bits of every value
	localparam int IN_W      = 32;           // start point and c, Q4.28
	localparam int INNER_W   = 48;           // z components and |z|^2, Q20.28
	localparam int CNT_W     = 16;           // iteration count and limit
	localparam int THR_W     = 32;           // escape threshold
	localparam int HALF_W    = INNER_W / 2;  // partial-product split point
	localparam int OPD_W     = HALF_W + 1;   // signed partial operand
	localparam int PP_W      = 2 * OPD_W;    // one partial product
	localparam int ACC_W     = 2 * INNER_W;  // full product accumulator
	localparam int MSTEP_W   = 3;            // multiplier sequence counter
	localparam int MUL_LAST_STEP = 5;        // step that loads the product

	localparam int QDEPTH    = 2;
	localparam int QPTR_W    = $clog2(QDEPTH);
	localparam int QCNT_W    = $clog2(QDEPTH + 1);

	localparam int CFG_IDX_W = 8;
	localparam logic [CFG_IDX_W-1:0] CFG_C_REAL    = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_C_IMAG    = 8'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ITER_LIM  = 8'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ESC_RAD2  = 8'd3;

	localparam logic [CNT_W-1:0] ITER_LIM_RST = 16'd256;
	localparam logic [THR_W-1:0] ESC_RAD2_RST = 32'd1073741824;

	// live configuration seen by the engine
	typedef struct packed {
		logic [IN_W-1:0]  c_real;
		logic [IN_W-1:0]  c_imag;
		logic [CNT_W-1:0] iter_lim;
		logic [THR_W-1:0] esc_rad2;
	} cfg_t;

	// one queued word: start point plus its class
	typedef struct packed {
		logic [IN_W-1:0] re;
		logic [IN_W-1:0] im;
		logic            zero_limit;
	} entry_t;

	// saturate a value two bits wider than a z component
	function automatic logic [INNER_W-1:0] sat_inner(input logic [INNER_W+1:0] v);
		logic [INNER_W-1:0] r;
		if (&v[INNER_W+1:INNER_W-1] || ~|v[INNER_W+1:INNER_W-1]) begin
			r = v[INNER_W-1:0];
		end else if (v[INNER_W+1]) begin
			r = {1'b1, {(INNER_W-1){1'b0}}};
		end else begin
			r = {1'b0, {(INNER_W-1){1'b1}}};
		end
		return r;
	endfunction

endpackage

[src/jet_front.sv]
// ----------------------------------------------------------------------------
// jet_front: command intake and start-point queue
// Takes start words, tags a zero iteration limit, and buffers them for the engine.
// ----------------------------------------------------------------------------
module jet_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [jet_pkg::IN_W-1:0]      start_real,
	input  logic [jet_pkg::IN_W-1:0]      start_imag,
	input  logic [jet_pkg::CNT_W-1:0]     iter_lim,
	output logic                          busy,
	output logic                          q_valid,
	output jet_pkg::entry_t               q_entry,
	input  logic                          q_pop
);

	jet_pkg::entry_t                  ent_q [jet_pkg::QDEPTH];
	logic [jet_pkg::QPTR_W-1:0]       wr_ptr_q;
	logic [jet_pkg::QPTR_W-1:0]       rd_ptr_q;
	logic [jet_pkg::QCNT_W-1:0]       cnt_q;
	logic                             push;

	assign busy    = (cnt_q == jet_pkg::QCNT_W'(jet_pkg::QDEPTH));
	assign q_valid = (cnt_q != '0);
	assign q_entry = ent_q[rd_ptr_q];
	assign push    = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (q_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !q_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!push && q_pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q].re         <= start_real;
			ent_q[wr_ptr_q].im         <= start_imag;
			ent_q[wr_ptr_q].zero_limit <= (iter_lim == '0);
		end
	end

endmodule

[src/jet_mul.sv]
// ----------------------------------------------------------------------------
// jet_mul: sequential 48x48 signed multiply with floor shift and saturation
// Four 25x25 partial products, accumulated in sequence before the result is loaded.
// ----------------------------------------------------------------------------
module jet_mul (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          go,
	input  logic                          half,   // shift by FRAC_BITS-1 (doubled product)
	input  logic [jet_pkg::INNER_W-1:0]   a,
	input  logic [jet_pkg::INNER_W-1:0]   b,
	output logic                          done,
	output logic [jet_pkg::INNER_W-1:0]   p
);

	logic                             busy_q;
	logic [jet_pkg::MSTEP_W-1:0]      step_q;
	logic                             half_q;
	logic [jet_pkg::INNER_W-1:0]      a_q;
	logic [jet_pkg::INNER_W-1:0]      b_q;
	logic signed [jet_pkg::PP_W-1:0]  pp_s1;
	logic [1:0]                       off_s1;
	logic signed [jet_pkg::ACC_W-1:0] acc_q;
	logic [jet_pkg::INNER_W-1:0]      p_q;
	logic                             done_q;

	logic signed [jet_pkg::OPD_W-1:0] opa;
	logic signed [jet_pkg::OPD_W-1:0] opb;
	logic signed [jet_pkg::PP_W-1:0]  pp_next;
	logic signed [jet_pkg::ACC_W-1:0] pp_ext;
	logic signed [jet_pkg::ACC_W-1:0] pp_term;
	logic signed [jet_pkg::ACC_W-1:0] shifted;
	logic [jet_pkg::INNER_W-1:0]      p_sat;

	// low halves are unsigned, high halves carry the sign
	always_comb begin
		unique case (step_q[1:0])
			2'd0: begin
				opa = {1'b0, a_q[jet_pkg::HALF_W-1:0]};
				opb = {1'b0, b_q[jet_pkg::HALF_W-1:0]};
			end
			2'd1: begin
				opa = {1'b0, a_q[jet_pkg::HALF_W-1:0]};
				opb = {b_q[jet_pkg::INNER_W-1], b_q[jet_pkg::INNER_W-1:jet_pkg::HALF_W]};
			end
			2'd2: begin
				opa = {a_q[jet_pkg::INNER_W-1], a_q[jet_pkg::INNER_W-1:jet_pkg::HALF_W]};
				opb = {1'b0, b_q[jet_pkg::HALF_W-1:0]};
			end
			2'd3: begin
				opa = {a_q[jet_pkg::INNER_W-1], a_q[jet_pkg::INNER_W-1:jet_pkg::HALF_W]};
				opb = {b_q[jet_pkg::INNER_W-1], b_q[jet_pkg::INNER_W-1:jet_pkg::HALF_W]};
			end
		endcase
	end

	assign pp_next = jet_pkg::PP_W'(opa) * jet_pkg::PP_W'(opb);
	assign pp_ext  = {{(jet_pkg::ACC_W-jet_pkg::PP_W){pp_s1[jet_pkg::PP_W-1]}}, pp_s1};

	always_comb begin
		unique case (off_s1)
			2'd0:       pp_term = pp_ext;
			2'd1, 2'd2: pp_term = pp_ext <<< jet_pkg::HALF_W;
			2'd3:       pp_term = pp_ext <<< (2 * jet_pkg::HALF_W);
		endcase
	end

	// arithmetic shift is floor; then clamp to the signed 48-bit range
	always_comb begin
		shifted = half_q ? (acc_q >>> (jet_pkg::FRAC_BITS - 1)) : (acc_q >>> jet_pkg::FRAC_BITS);
		if (&shifted[jet_pkg::ACC_W-1:jet_pkg::INNER_W-1]
				|| ~|shifted[jet_pkg::ACC_W-1:jet_pkg::INNER_W-1]) begin
			p_sat = shifted[jet_pkg::INNER_W-1:0];
		end else if (shifted[jet_pkg::ACC_W-1]) begin
			p_sat = {1'b1, {(jet_pkg::INNER_W-1){1'b0}}};
		end else begin
			p_sat = {1'b0, {(jet_pkg::INNER_W-1){1'b1}}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && (step_q == jet_pkg::MSTEP_W'(jet_pkg::MUL_LAST_STEP));
			if (go) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				if (step_q == jet_pkg::MSTEP_W'(jet_pkg::MUL_LAST_STEP)) begin
					busy_q <= 1'b0;
				end
				step_q <= step_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			a_q    <= a;
			b_q    <= b;
			half_q <= half;
		end
		if (busy_q) begin
			if (step_q < jet_pkg::MSTEP_W'(4)) begin
				pp_s1  <= pp_next;
				off_s1 <= step_q[1:0];
			end
			if (step_q == '0) begin
				acc_q <= '0;
			end else if (step_q < jet_pkg::MSTEP_W'(jet_pkg::MUL_LAST_STEP)) begin
				acc_q <= acc_q + pp_term;
			end
			if (step_q == jet_pkg::MSTEP_W'(jet_pkg::MUL_LAST_STEP)) begin
				p_q <= p_sat;
			end
		end
	end

	assign done = done_q;
	assign p    = p_q;

endmodule

[src/jet_engine.sv]
// ----------------------------------------------------------------------------
// jet_engine: escape-time iteration engine
// Pops start points, runs z = z*z + c on three multipliers, emits one result.
// ----------------------------------------------------------------------------
module jet_engine (
	input  logic                          clk,
	input  logic                          arst_n,
	input  jet_pkg::cfg_t                 cfg,
	input  logic                          q_valid,
	input  jet_pkg::entry_t               q_entry,
	output logic                          q_pop,
	output logic                          done,
	output logic [jet_pkg::CNT_W-1:0]     escape_count,
	output logic                          did_escape,
	output logic [jet_pkg::INNER_W-1:0]   escape_magnitude_sq
);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_WAIT = 3'b010,
		S_NEXT = 3'b100
	} state_t;

	state_t                           state_q;
	logic                             first_q;
	logic [jet_pkg::CNT_W-1:0]        count_q;
	logic                             done_q;
	logic [jet_pkg::CNT_W-1:0]        cnt_o_q;
	logic                             esc_o_q;
	logic [jet_pkg::INNER_W-1:0]      mag_o_q;

	logic                             go;
	logic [jet_pkg::INNER_W-1:0]      z_re;
	logic [jet_pkg::INNER_W-1:0]      z_im;
	logic [jet_pkg::INNER_W-1:0]      rr_p;
	logic [jet_pkg::INNER_W-1:0]      ii_p;
	logic [jet_pkg::INNER_W-1:0]      ri_p;
	logic                             rr_done;
	logic                             ii_done;
	logic                             ri_done;
	logic [jet_pkg::INNER_W+1:0]      re_sum;
	logic [jet_pkg::INNER_W+1:0]      im_sum;
	logic [jet_pkg::INNER_W-1:0]      mag;
	logic                             escaped;
	logic [jet_pkg::CNT_W-1:0]        count_inc;

	assign q_pop = (state_q == S_IDLE) && q_valid;
	assign go    = (q_pop && !q_entry.zero_limit) || (state_q == S_NEXT);

	// next z from the products of the current one
	assign re_sum = {{2{rr_p[jet_pkg::INNER_W-1]}}, rr_p}
	              - {{2{ii_p[jet_pkg::INNER_W-1]}}, ii_p}
	              + {{(jet_pkg::INNER_W+2-jet_pkg::IN_W){cfg.c_real[jet_pkg::IN_W-1]}},
	                 cfg.c_real};
	assign im_sum = {{2{ri_p[jet_pkg::INNER_W-1]}}, ri_p}
	              + {{(jet_pkg::INNER_W+2-jet_pkg::IN_W){cfg.c_imag[jet_pkg::IN_W-1]}},
	                 cfg.c_imag};

	always_comb begin
		if (state_q == S_IDLE) begin
			z_re = {{(jet_pkg::INNER_W-jet_pkg::IN_W){q_entry.re[jet_pkg::IN_W-1]}}, q_entry.re};
			z_im = {{(jet_pkg::INNER_W-jet_pkg::IN_W){q_entry.im[jet_pkg::IN_W-1]}}, q_entry.im};
		end else begin
			z_re = jet_pkg::sat_inner(re_sum);
			z_im = jet_pkg::sat_inner(im_sum);
		end
	end

	// squares are never negative and each stays below 2^47
	assign mag       = rr_p + ii_p;
	assign escaped   = mag > {{(jet_pkg::INNER_W-jet_pkg::THR_W){1'b0}}, cfg.esc_rad2};
	assign count_inc = count_q + 1'b1;

	jet_mul u_mul_rr (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (go),
		.half   (1'b0),
		.a      (z_re),
		.b      (z_re),
		.done   (rr_done),
		.p      (rr_p)
	);

	jet_mul u_mul_ii (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (go),
		.half   (1'b0),
		.a      (z_im),
		.b      (z_im),
		.done   (ii_done),
		.p      (ii_p)
	);

	jet_mul u_mul_ri (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (go),
		.half   (1'b1),
		.a      (z_re),
		.b      (z_im),
		.done   (ri_done),
		.p      (ri_p)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			first_q <= 1'b0;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (q_pop) begin
						if (q_entry.zero_limit) begin
							done_q <= 1'b1;
						end else begin
							first_q <= 1'b1;
							count_q <= '0;
							state_q <= S_WAIT;
						end
					end
				end
				S_WAIT: begin
					// all three units run in lock step
					if (rr_done && ii_done && ri_done) begin
						priority if (first_q) begin
							first_q <= 1'b0;
							state_q <= S_NEXT;
						end else if (escaped) begin
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end else if (count_inc == cfg.iter_lim) begin
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							count_q <= count_inc;
							state_q <= S_NEXT;
						end
					end
				end
				S_NEXT: begin
					state_q <= S_WAIT;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// result word, valid with done_q
	always_ff @(posedge clk) begin
		if (q_pop && q_entry.zero_limit) begin
			cnt_o_q <= '0;
			esc_o_q <= 1'b0;
			mag_o_q <= '0;
		end else if (state_q == S_WAIT && !first_q) begin
			if (escaped) begin
				cnt_o_q <= count_q;
				esc_o_q <= 1'b1;
				mag_o_q <= mag;
			end else begin
				cnt_o_q <= count_inc;
				esc_o_q <= 1'b0;
				mag_o_q <= '0;
			end
		end
	end

	assign done                = done_q;
	assign escape_count        = cnt_o_q;
	assign did_escape          = esc_o_q;
	assign escape_magnitude_sq = mag_o_q;

endmodule

[src/julia_escape_time_core.sv]
// ----------------------------------------------------------------------------
// julia_escape_time_core: Julia set escape-time iterator
// Per start point, iterates z = z*z + c and reports when and how it escaped.
// ----------------------------------------------------------------------------
// Pulse start with a start point while busy is low; busy rises only when the
// two-word start queue is full. Each point yields exactly one result word,
// shown for one cycle with done high; there is no back-pressure, so capture it
// then. A point takes one setup pass plus k iteration passes, where k is the
// escape count plus one for an escaping point, or iteration_limit for a
// bounded one (the default limit is 256). Each pass runs the 48x48
// multiplies (three units in lock step), each done as four 25x25 partial
// products; an iteration pass then tests |z|^2 before the next z is formed.
// A zero limit gives count 0 at once. cfg_ready is always high; write the
// registers only while no point is in flight. Arithmetic is signed Q4.28 in,
// Q20.28 inside, floor on every product, saturation on every product and on
// each sum that forms z.
// ----------------------------------------------------------------------------
module julia_escape_time_core (
	input  logic                            clk,
	input  logic                            arst_n,
	// start channel
	input  logic                            start,
	output logic                            busy,
	input  logic [jet_pkg::IN_W-1:0]        start_real,
	input  logic [jet_pkg::IN_W-1:0]        start_imag,
	// result channel
	output logic                            done,
	output logic [jet_pkg::CNT_W-1:0]       escape_count,
	output logic                            did_escape,
	output logic [jet_pkg::INNER_W-1:0]     escape_magnitude_sq,
	// register write channel
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [jet_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [jet_pkg::IN_W-1:0]        cfg_data
);

	jet_pkg::cfg_t   cfg_q;
	logic            q_valid;
	jet_pkg::entry_t q_entry;
	logic            q_pop;

	assign cfg_ready = 1'b1;

	// register file; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.c_real   <= '0;
			cfg_q.c_imag   <= '0;
			cfg_q.iter_lim <= jet_pkg::ITER_LIM_RST;
			cfg_q.esc_rad2 <= jet_pkg::ESC_RAD2_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				jet_pkg::CFG_C_REAL:   cfg_q.c_real   <= cfg_data;
				jet_pkg::CFG_C_IMAG:   cfg_q.c_imag   <= cfg_data;
				jet_pkg::CFG_ITER_LIM: cfg_q.iter_lim <= cfg_data[jet_pkg::CNT_W-1:0];
				jet_pkg::CFG_ESC_RAD2: cfg_q.esc_rad2 <= cfg_data[jet_pkg::THR_W-1:0];
				default: ;
			endcase
		end
	end

	// front: intake and queue
	jet_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.start_real (start_real),
		.start_imag (start_imag),
		.iter_lim   (cfg_q.iter_lim),
		.busy       (busy),
		.q_valid    (q_valid),
		.q_entry    (q_entry),
		.q_pop      (q_pop)
	);

	// back: iteration engine
	jet_engine u_engine (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cfg                 (cfg_q),
		.q_valid             (q_valid),
		.q_entry             (q_entry),
		.q_pop               (q_pop),
		.done                (done),
		.escape_count        (escape_count),
		.did_escape          (did_escape),
		.escape_magnitude_sq (escape_magnitude_sq)
	);

`ifndef NO_ASSERTIONS
	// bounded points report no magnitude
	a_bounded_mag_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !did_escape |-> escape_magnitude_sq == '0)
		else $error("bounded result carries a magnitude");

	// an escape means |z|^2 beat a threshold that is at least zero
	a_escape_mag_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		done && did_escape |-> escape_magnitude_sq != '0)
		else $error("escape reported with zero magnitude");

	// a full queue always has a word for the engine
	a_busy_has_word: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> q_valid)
		else $error("busy with empty queue");

	// the engine never pops an empty queue
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("pop from empty queue");
`endif

endmodule
